// ----- design/slx_pkg.sv -----
// Shared types and token kind codes for the byte-stream script lexer.
// No dependencies; imported by slx_core and script_lexer_byte_stream.
`timescale 1ns / 1ps

package slx_pkg;

  localparam logic [4:0] K_INT    = 5'd0;
  localparam logic [4:0] K_STR    = 5'd1;
  localparam logic [4:0] K_PLUS   = 5'd2;
  localparam logic [4:0] K_MINUS  = 5'd3;
  localparam logic [4:0] K_STAR   = 5'd4;
  localparam logic [4:0] K_DIV    = 5'd5;
  localparam logic [4:0] K_LPAREN = 5'd6;
  localparam logic [4:0] K_RPAREN = 5'd7;
  localparam logic [4:0] K_LBRACE = 5'd8;
  localparam logic [4:0] K_RBRACE = 5'd9;
  localparam logic [4:0] K_ASSIGN = 5'd10;
  localparam logic [4:0] K_SEMI   = 5'd11;
  localparam logic [4:0] K_DOT    = 5'd12;
  localparam logic [4:0] K_USESTD = 5'd13;
  localparam logic [4:0] K_USE    = 5'd14;
  localparam logic [4:0] K_IDENT  = 5'd15;
  localparam logic [4:0] K_EOF    = 5'd16;
  localparam logic [4:0] K_NONE   = 5'd17;
  localparam logic [4:0] K_TEXT   = 5'd18;
  localparam logic [4:0] K_ERR    = 5'd19;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_ILLEGAL = 2'd1;
  localparam logic [1:0] E_USEFORM = 2'd2;
  localparam logic [1:0] E_UNTERM  = 2'd3;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [4:0]  kind;
    logic [30:0] number_value;
    logic [7:0]  char_out;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  // Results raised by one input byte, slot 0 first
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     res;
  } push_t;

endpackage

// ----- design/slx_core.sv -----
// Lexer core: lexer mode and number accumulator registers, and the logic that
// turns one registered byte into up to three results. Uses slx_pkg.
`timescale 1ns / 1ps

module slx_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_eot_i,
  output slx_pkg::push_t push_o
);
  import slx_pkg::*;

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_SLASH      = 4'd1;
  localparam logic [3:0] M_LINE       = 4'd2;
  localparam logic [3:0] M_BLOCK      = 4'd3;
  localparam logic [3:0] M_BLOCK_STAR = 4'd4;
  localparam logic [3:0] M_NUMBER     = 4'd5;
  localparam logic [3:0] M_IDENT      = 4'd6;
  localparam logic [3:0] M_STRING     = 4'd7;
  localparam logic [3:0] M_AT         = 4'd8;
  localparam logic [3:0] M_AT_U       = 4'd9;
  localparam logic [3:0] M_AT_US      = 4'd10;
  localparam logic [3:0] M_AT_USE     = 4'd11;
  localparam logic [3:0] M_USE_SEL    = 4'd12;
  localparam logic [3:0] M_USE_STD    = 4'd13;
  localparam logic [3:0] M_USE_Q      = 4'd14;
  localparam logic [3:0] M_ERROR      = 4'd15;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_E     = 8'h65;

  typedef struct packed {
    logic [3:0]  mode;
    logic [30:0] acc;
    logic        hit;
    result_t     res;
  } idle_t;

  logic [3:0]  mode_q, mode_d;
  logic [30:0] acc_q, acc_d;
  result_t     r0, r1, r2;
  logic [1:0]  n;
  idle_t       li;
  logic [34:0] prod;

  function automatic result_t mk(input logic [4:0] kind, input logic [30:0] val,
                                 input logic [7:0] ch, input logic [1:0] err,
                                 input logic last);
    result_t r;
    r.kind         = kind;
    r.number_value = val;
    r.char_out     = ch;
    r.error_code   = err;
    r.last         = last;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Punctuator lookup: {valid, kind}
  function automatic logic [5:0] punct(input logic [7:0] c);
    logic [5:0] p;
    unique case (c)
      8'h2B:   p = {1'b1, K_PLUS};
      8'h2D:   p = {1'b1, K_MINUS};
      8'h2A:   p = {1'b1, K_STAR};
      8'h28:   p = {1'b1, K_LPAREN};
      8'h29:   p = {1'b1, K_RPAREN};
      8'h7B:   p = {1'b1, K_LBRACE};
      8'h7D:   p = {1'b1, K_RBRACE};
      8'h3D:   p = {1'b1, K_ASSIGN};
      8'h3B:   p = {1'b1, K_SEMI};
      8'h2E:   p = {1'b1, K_DOT};
      default: p = 6'd0;
    endcase
    return p;
  endfunction

  function automatic idle_t lex_idle(input logic [7:0] c, input logic [30:0] acc);
    idle_t      r;
    logic [5:0] pk;
    pk    = punct(c);
    r.mode = M_IDLE;
    r.acc  = acc;
    r.hit  = 1'b0;
    r.res  = '0;
    priority if (c == CH_SP || c == CH_NL || c == CH_TAB || c == CH_CR) begin
      r.mode = M_IDLE;
    end else if (c == CH_SLASH) begin
      r.mode = M_SLASH;
    end else if (is_digit(c)) begin
      r.acc  = 31'(c[3:0]);
      r.mode = M_NUMBER;
    end else if (c == CH_QUOTE) begin
      r.mode = M_STRING;
    end else if (c == CH_AT) begin
      r.mode = M_AT;
    end else if (is_alpha(c) || c == CH_UNDER) begin
      r.hit  = 1'b1;
      r.res  = mk(K_TEXT, '0, c, E_NONE, 1'b0);
      r.mode = M_IDENT;
    end else if (pk[5]) begin
      r.hit = 1'b1;
      r.res = mk(pk[4:0], '0, '0, E_NONE, 1'b0);
    end else begin
      r.hit  = 1'b1;
      r.res  = mk(K_ERR, '0, c, E_ILLEGAL, 1'b1);
      r.mode = M_ERROR;
      r.acc  = '0;
    end
    return r;
  endfunction

  assign prod = 35'({acc_q, 3'b000}) + 35'({acc_q, 1'b0}) + 35'(in_byte_i[3:0]);

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    r0     = '0;
    r1     = '0;
    r2     = '0;
    n      = 2'd0;
    li     = lex_idle(in_byte_i, acc_q);
    if (in_valid_i && in_eot_i) begin
      mode_d = M_IDLE;
      acc_d  = '0;
      unique case (mode_q)
        M_SLASH, M_NUMBER, M_IDENT: begin
          if (mode_q == M_SLASH) begin
            r0 = mk(K_DIV, '0, '0, E_NONE, 1'b0);
          end else if (mode_q == M_NUMBER) begin
            r0 = mk(K_INT, acc_q, '0, E_NONE, 1'b0);
          end else begin
            r0 = mk(K_IDENT, '0, '0, E_NONE, 1'b0);
          end
          r1 = mk(K_EOF, '0, '0, E_NONE, 1'b0);
          r2 = mk(K_NONE, '0, '0, E_NONE, 1'b1);
          n  = 2'd3;
        end
        M_BLOCK, M_BLOCK_STAR, M_STRING, M_USE_STD, M_USE_Q: begin
          r0 = mk(K_ERR, '0, '0, E_UNTERM, 1'b1);
          n  = 2'd1;
        end
        M_AT, M_AT_U, M_AT_US, M_AT_USE: begin
          r0 = mk(K_ERR, '0, CH_AT, E_ILLEGAL, 1'b1);
          n  = 2'd1;
        end
        M_USE_SEL: begin
          r0 = mk(K_ERR, '0, '0, E_USEFORM, 1'b1);
          n  = 2'd1;
        end
        M_ERROR: begin
          n = 2'd0;
        end
        default: begin
          r0 = mk(K_EOF, '0, '0, E_NONE, 1'b0);
          r1 = mk(K_NONE, '0, '0, E_NONE, 1'b1);
          n  = 2'd2;
        end
      endcase
    end else if (in_valid_i) begin
      unique case (mode_q)
        M_SLASH: begin
          if (in_byte_i == CH_SLASH) begin
            mode_d = M_LINE;
          end else if (in_byte_i == CH_STAR) begin
            mode_d = M_BLOCK;
          end else begin
            r0     = mk(K_DIV, '0, '0, E_NONE, 1'b0);
            r1     = li.res;
            n      = li.hit ? 2'd2 : 2'd1;
            mode_d = li.mode;
            acc_d  = li.acc;
          end
        end
        M_LINE: begin
          if (in_byte_i == CH_NL) mode_d = M_IDLE;
        end
        M_BLOCK: begin
          if (in_byte_i == CH_STAR) mode_d = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (in_byte_i == CH_SLASH) begin
            mode_d = M_IDLE;
          end else if (in_byte_i != CH_STAR) begin
            mode_d = M_BLOCK;
          end
        end
        M_NUMBER: begin
          if (is_digit(in_byte_i)) begin
            acc_d = (prod > 35'(NUM_MAX)) ? NUM_MAX : prod[30:0];
          end else begin
            li     = lex_idle(in_byte_i, '0);
            r0     = mk(K_INT, acc_q, '0, E_NONE, 1'b0);
            r1     = li.res;
            n      = li.hit ? 2'd2 : 2'd1;
            mode_d = li.mode;
            acc_d  = li.acc;
          end
        end
        M_IDENT: begin
          if (is_alpha(in_byte_i) || is_digit(in_byte_i) || in_byte_i == CH_UNDER) begin
            r0 = mk(K_TEXT, '0, in_byte_i, E_NONE, 1'b0);
            n  = 2'd1;
          end else begin
            r0     = mk(K_IDENT, '0, '0, E_NONE, 1'b0);
            r1     = li.res;
            n      = li.hit ? 2'd2 : 2'd1;
            mode_d = li.mode;
            acc_d  = li.acc;
          end
        end
        M_STRING, M_USE_STD, M_USE_Q: begin
          if (mode_q == M_STRING && in_byte_i == CH_QUOTE) begin
            r0     = mk(K_STR, '0, '0, E_NONE, 1'b0);
            mode_d = M_IDLE;
          end else if (mode_q == M_USE_STD && in_byte_i == CH_GT) begin
            r0     = mk(K_USESTD, '0, '0, E_NONE, 1'b0);
            mode_d = M_IDLE;
          end else if (mode_q == M_USE_Q && in_byte_i == CH_QUOTE) begin
            r0     = mk(K_USE, '0, '0, E_NONE, 1'b0);
            mode_d = M_IDLE;
          end else begin
            r0 = mk(K_TEXT, '0, in_byte_i, E_NONE, 1'b0);
          end
          n = 2'd1;
        end
        M_AT, M_AT_U, M_AT_US, M_AT_USE: begin
          if (mode_q == M_AT && in_byte_i == CH_U) begin
            mode_d = M_AT_U;
          end else if (mode_q == M_AT_U && in_byte_i == CH_S) begin
            mode_d = M_AT_US;
          end else if (mode_q == M_AT_US && in_byte_i == CH_E) begin
            mode_d = M_AT_USE;
          end else if (mode_q == M_AT_USE && in_byte_i == CH_SP) begin
            mode_d = M_USE_SEL;
          end else begin
            r0     = mk(K_ERR, '0, CH_AT, E_ILLEGAL, 1'b1);
            n      = 2'd1;
            mode_d = M_ERROR;
            acc_d  = '0;
          end
        end
        M_USE_SEL: begin
          if (in_byte_i == CH_LT) begin
            mode_d = M_USE_STD;
          end else if (in_byte_i == CH_QUOTE) begin
            mode_d = M_USE_Q;
          end else begin
            r0     = mk(K_ERR, '0, in_byte_i, E_USEFORM, 1'b1);
            n      = 2'd1;
            mode_d = M_ERROR;
            acc_d  = '0;
          end
        end
        M_ERROR: begin
          mode_d = M_ERROR;
        end
        default: begin
          r0     = li.res;
          n      = li.hit ? 2'd1 : 2'd0;
          mode_d = li.mode;
          acc_d  = li.acc;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      acc_q  <= '0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

  assign push_o.cnt    = n;
  assign push_o.res[0] = r0;
  assign push_o.res[1] = r1;
  assign push_o.res[2] = r2;

endmodule

// ----- design/script_lexer_byte_stream.sv -----
// Byte-stream script lexer: one source byte per transaction in, token results out.
// Top level: input register, slx_core and the result queue. Uses slx_pkg.
//
// Channels: s_axis carries one source byte per transaction in tdata[7:0]; tlast
// high marks end of text (tdata is then ignored). m_axis carries one result per
// transaction: tuser is the token kind, tdata holds number value, character and
// error code, tlast marks the final result of a text (NONE or an error).
// An accepted byte is held in the input register and its results are then
// written into the result queue, whose head is offered on m_axis.
// Throughput: one byte per cycle while s_axis_tready is high. A byte raises
// zero to three results; the queue drains one result per cycle while
// m_axis_tready is high. s_axis_tready is high while the queue has room for
// two more bytes' worth of results (six entries). Reset clears the lexer mode,
// the number accumulator, the input valid flag and the queue count and pointers.
// A stalled receiver fills the queue, then s_axis_tready is held low; no result
// is dropped. FIFO_DEPTH must be a power of two, 8 or more; it is not checked.
`timescale 1ns / 1ps

module script_lexer_byte_stream #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [30:0] number_value, [38:31] char_out,
                                     // [40:39] error_code, [47:41] zero
  output logic [4:0]  m_axis_tuser,  // [4:0] kind
  output logic        m_axis_tlast
);
  import slx_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_eot_q;
  push_t            push;
  result_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             s_acc, pop;
  result_t          head;

  assign s_axis_tready = (count_q <= CNT_W'(FIFO_DEPTH - 6));
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign count_d       = count_q + CNT_W'(push.cnt) - CNT_W'(pop);

  slx_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_q),
    .in_byte_i (in_byte_q),
    .in_eot_i  (in_eot_q),
    .push_o    (push)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      in_valid_q <= s_acc;
      wr_ptr_q   <= wr_ptr_q + PTR_W'(push.cnt);
      rd_ptr_q   <= rd_ptr_q + PTR_W'(pop);
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.cnt) begin
        mem_q[wr_ptr_q + PTR_W'(i)] <= push.res[i];
      end
    end
  end

  assign head          = mem_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {7'd0, head.error_code, head.char_out, head.number_value};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == K_NONE || m_axis_tuser == K_ERR)
    else $error("last result is neither NONE nor error");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != K_ERR |-> m_axis_tdata[40:39] == E_NONE)
    else $error("error code on a non-error result");

  a_num_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != K_INT |-> m_axis_tdata[30:0] == '0)
    else $error("number value on a non-integer result");
`endif

endmodule

// ----- test/tb_script_lexer_byte_stream.sv -----
// Self-checking testbench for script_lexer_byte_stream: directed and random source text
// against a behavioural lexer model held in a small scoreboard class.
// Depends on slx_pkg and the script_lexer_byte_stream RTL.
`timescale 1ns / 1ps

module tb_script_lexer_byte_stream;
  import slx_pkg::*;

  localparam logic [4:0] NO_PUNCT = 5'd31;

  typedef enum logic [4:0] {
    LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_NUMBER, LX_IDENT,
    LX_STRING, LX_AT, LX_AT_U, LX_AT_US, LX_AT_USE, LX_USE_SEL, LX_USE_STD,
    LX_USE_Q, LX_DISCARD
  } lex_mode_e;

  typedef struct packed {
    logic       eot;
    logic [7:0] b;
  } src_byte_t;

  class lex_scoreboard;
    lex_mode_e   mode;
    logic [30:0] acc;
    result_t     tokens_due[$];
    int unsigned faults;

    function new();
      mode = LX_IDLE;
      acc = '0;
      faults = 0;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function void emit(logic [4:0] kind, logic [30:0] val, logic [7:0] ch,
                       logic [1:0] err, logic fin);
      result_t r;
      r.kind = kind;
      r.number_value = val;
      r.char_out = ch;
      r.error_code = err;
      r.last = fin;
      tokens_due.push_back(r);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic [4:0] punct_code(logic [7:0] c);
      case (c)
        "+": return K_PLUS;
        "-": return K_MINUS;
        "*": return K_STAR;
        "(": return K_LPAREN;
        ")": return K_RPAREN;
        "{": return K_LBRACE;
        "}": return K_RBRACE;
        "=": return K_ASSIGN;
        ";": return K_SEMI;
        ".": return K_DOT;
        default: return NO_PUNCT;
      endcase
    endfunction

    function void raise_error(logic [7:0] ch, logic [1:0] code);
      emit(K_ERR, '0, ch, code, 1'b1);
      mode = LX_DISCARD;
      acc = '0;
    endfunction

    function void close_text();
      emit(K_EOF, '0, '0, E_NONE, 1'b0);
      emit(K_NONE, '0, '0, E_NONE, 1'b1);
    endfunction

    function void start_token(logic [7:0] c);
      logic [4:0] pk;
      pk = punct_code(c);
      mode = LX_IDLE;
      if (c == " " || c == "\n" || c == "\t" || c == "\r") begin
        return;
      end else if (c == "/") begin
        mode = LX_SLASH;
      end else if (is_digit(c)) begin
        acc = 31'(c - 8'h30);
        mode = LX_NUMBER;
      end else if (c == "\"") begin
        mode = LX_STRING;
      end else if (c == "@") begin
        mode = LX_AT;
      end else if (is_alpha(c) || c == "_") begin
        emit(K_TEXT, '0, c, E_NONE, 1'b0);
        mode = LX_IDENT;
      end else if (pk != NO_PUNCT) begin
        emit(pk, '0, '0, E_NONE, 1'b0);
      end else begin
        raise_error(c, E_ILLEGAL);
      end
    endfunction

    function void note_byte(logic [7:0] c, logic eot);
      logic [34:0] wide;
      if (eot) begin
        case (mode)
          LX_SLASH: begin
            emit(K_DIV, '0, '0, E_NONE, 1'b0);
            close_text();
          end
          LX_NUMBER: begin
            emit(K_INT, acc, '0, E_NONE, 1'b0);
            close_text();
          end
          LX_IDENT: begin
            emit(K_IDENT, '0, '0, E_NONE, 1'b0);
            close_text();
          end
          LX_BLOCK, LX_BLOCK_STAR, LX_STRING, LX_USE_STD, LX_USE_Q: raise_error('0, E_UNTERM);
          LX_AT, LX_AT_U, LX_AT_US, LX_AT_USE: raise_error("@", E_ILLEGAL);
          LX_USE_SEL: raise_error('0, E_USEFORM);
          LX_DISCARD: ;
          default: close_text();
        endcase
        mode = LX_IDLE;
        acc = '0;
        return;
      end
      case (mode)
        LX_SLASH: begin
          if (c == "/") mode = LX_LINE;
          else if (c == "*") mode = LX_BLOCK;
          else begin
            emit(K_DIV, '0, '0, E_NONE, 1'b0);
            start_token(c);
          end
        end
        LX_LINE: if (c == "\n") mode = LX_IDLE;
        LX_BLOCK: if (c == "*") mode = LX_BLOCK_STAR;
        LX_BLOCK_STAR: begin
          if (c == "/") mode = LX_IDLE;
          else if (c != "*") mode = LX_BLOCK;
        end
        LX_NUMBER: begin
          if (is_digit(c)) begin
            wide = 35'(acc) * 35'd10 + 35'(c - 8'h30);
            acc = (wide > 35'(NUM_MAX)) ? NUM_MAX : wide[30:0];
          end else begin
            emit(K_INT, acc, '0, E_NONE, 1'b0);
            acc = '0;
            start_token(c);
          end
        end
        LX_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            emit(K_TEXT, '0, c, E_NONE, 1'b0);
          end else begin
            emit(K_IDENT, '0, '0, E_NONE, 1'b0);
            start_token(c);
          end
        end
        LX_STRING: begin
          if (c == "\"") begin
            emit(K_STR, '0, '0, E_NONE, 1'b0);
            mode = LX_IDLE;
          end else begin
            emit(K_TEXT, '0, c, E_NONE, 1'b0);
          end
        end
        LX_AT: if (c == "u") mode = LX_AT_U; else raise_error("@", E_ILLEGAL);
        LX_AT_U: if (c == "s") mode = LX_AT_US; else raise_error("@", E_ILLEGAL);
        LX_AT_US: if (c == "e") mode = LX_AT_USE; else raise_error("@", E_ILLEGAL);
        LX_AT_USE: if (c == " ") mode = LX_USE_SEL; else raise_error("@", E_ILLEGAL);
        LX_USE_SEL: begin
          if (c == "<") mode = LX_USE_STD;
          else if (c == "\"") mode = LX_USE_Q;
          else raise_error(c, E_USEFORM);
        end
        LX_USE_STD: begin
          if (c == ">") begin
            emit(K_USESTD, '0, '0, E_NONE, 1'b0);
            mode = LX_IDLE;
          end else begin
            emit(K_TEXT, '0, c, E_NONE, 1'b0);
          end
        end
        LX_USE_Q: begin
          if (c == "\"") begin
            emit(K_USE, '0, '0, E_NONE, 1'b0);
            mode = LX_IDLE;
          end else begin
            emit(K_TEXT, '0, c, E_NONE, 1'b0);
          end
        end
        LX_DISCARD: ;
        default: start_token(c);
      endcase
    endfunction

    function void check_result(logic [4:0] kind, logic [47:0] data, logic fin);
      result_t want;
      if (tokens_due.size() == 0) begin
        $error("unexpected result: kind %0d, data %h, last %0b", kind, data, fin);
        faults++;
        return;
      end
      want = tokens_due.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        faults++;
      end
      if (data[30:0] !== want.number_value) begin
        $error("number_value: expected %0d, got %0d", want.number_value, data[30:0]);
        faults++;
      end
      if (data[38:31] !== want.char_out) begin
        $error("char_out: expected %h, got %h", want.char_out, data[38:31]);
        faults++;
      end
      if (data[40:39] !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, data[40:39]);
        faults++;
      end
      if (fin !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, fin);
        faults++;
      end
      if (data[47:41] !== '0) begin
        $error("tdata padding: expected 0, got %h", data[47:41]);
        faults++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;

  lex_scoreboard sb;
  src_byte_t     src_q[$];
  bit            calm_tail;
  int            gap_pct;

  script_lexer_byte_stream u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void push_byte(logic [7:0] b);
    src_byte_t it;
    it.eot = 1'b0;
    it.b = b;
    src_q.push_back(it);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_eot();
    src_byte_t it;
    it.eot = 1'b1;
    it.b = 8'($urandom_range(0, 255));
    src_q.push_back(it);
  endfunction

  function automatic logic [7:0] byte_but(logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x);
    return b;
  endfunction

  function automatic bit legal_lead(logic [7:0] b);
    string lead = " \n\t\r/\"@_+-*(){}=;.";
    if ((b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) return 1;
    for (int i = 0; i < lead.len(); i++) if (lead[i] == b) return 1;
    return 0;
  endfunction

  function automatic void push_content(logic [7:0] stop, int n);
    repeat (n) push_byte(byte_but(stop));
  endfunction

  function automatic void push_ident();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) push_byte(8'("a" + r));
    else if (r < 52) push_byte(8'("A" + r - 26));
    else push_byte("_");
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 62);
      if (r < 26) push_byte(8'("a" + r));
      else if (r < 52) push_byte(8'("A" + r - 26));
      else if (r < 62) push_byte(8'("0" + r - 52));
      else push_byte("_");
    end
  endfunction

  function automatic void push_number();
    case ($urandom_range(0, 5))
      0: push_str("2147483647");
      1: push_str("2147483648");
      2: repeat ($urandom_range(10, 13)) push_byte(8'("0" + $urandom_range(0, 9)));
      default: repeat ($urandom_range(1, 4)) push_byte(8'("0" + $urandom_range(0, 9)));
    endcase
  endfunction

  function automatic void add_fragment();
    string spaces = " \n\t\r";
    string puncts = "+-*(){}=;.";
    case ($urandom_range(0, 11))
      0: push_byte(spaces[$urandom_range(0, 3)]);
      1: push_byte(puncts[$urandom_range(0, 9)]);
      2: push_byte("/");
      3: begin
        push_str("//");
        push_content("\n", $urandom_range(0, 5));
        push_byte("\n");
      end
      4: begin
        push_str("/*");
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) push_byte("*");
          else push_byte(byte_but("/"));
        end
        if ($urandom_range(0, 1)) push_byte("*");
        push_str("*/");
      end
      5: push_number();
      6: push_ident();
      7: begin
        push_byte("\"");
        push_content("\"", $urandom_range(0, 5));
        push_byte("\"");
      end
      8: begin
        push_str("@use <");
        push_content(">", $urandom_range(0, 4));
        push_byte(">");
      end
      9: begin
        push_str("@use \"");
        push_content("\"", $urandom_range(0, 4));
        push_byte("\"");
      end
      default: begin
        repeat ($urandom_range(1, 3)) push_byte(spaces[$urandom_range(0, 3)]);
      end
    endcase
  endfunction

  function automatic void add_breakage();
    string at_word = "use ";
    logic [7:0] b;
    int k;
    case ($urandom_range(0, 7))
      0: begin
        do b = 8'($urandom_range(0, 255)); while (legal_lead(b));
        push_byte(b);
      end
      1: begin
        k = $urandom_range(0, 3);
        push_byte("@");
        for (int i = 0; i < k; i++) push_byte(at_word[i]);
        push_byte(byte_but(at_word[k]));
      end
      2: begin
        push_str("@use ");
        do b = 8'($urandom_range(0, 255)); while (b == "<" || b == "\"");
        push_byte(b);
      end
      3: begin
        push_byte("\"");
        push_content("\"", $urandom_range(0, 4));
      end
      4: begin
        push_str("/*");
        push_content("/", $urandom_range(0, 4));
      end
      5: begin
        if ($urandom_range(0, 1)) push_str("@use <");
        else push_str("@use \"");
        push_content(">", $urandom_range(0, 3));
      end
      6: push_str("@use ");
      default: begin
        k = $urandom_range(0, 3);
        push_byte("@");
        for (int i = 0; i < k; i++) push_byte(at_word[i]);
      end
    endcase
    // trailing random bytes; after an error the block drops them
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_text();
    repeat ($urandom_range(1, 5)) add_fragment();
    if ($urandom_range(0, 4) == 0) add_breakage();
    push_eot();
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 12;
      default: return 40;
    endcase
  endfunction

  task automatic send_byte(src_byte_t it);
    if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it.b;
    s_axis_tlast <= it.eot;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(it.b, it.eot);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    int stall_left;
    int stall_pct;
    int slot;
    m_axis_tready = 1'b0;
    stall_left = 0;
    stall_pct = 0;
    slot = 0;
    forever begin
      @(negedge clk_i);
      slot++;
      if (slot % 25 == 0) stall_pct = pick_odds();
      if (stall_left == 0 && !calm_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int n_directed;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    calm_tail = 1'b0;
    gap_pct = 0;

    // every punctuator, a lone slash into a high illegal byte, discard to end of text
    push_str("+-*(){}=;./");
    push_byte(8'hFF);
    push_byte("x");
    push_eot();
    // zero byte is illegal
    push_byte(8'h00);
    push_eot();
    // number ended by an identifier, identifier ended by end of text
    push_str("7a");
    push_eot();
    // at-sign cut short by end of text
    push_byte("@");
    push_eot();
    // empty text
    push_eot();
    n_directed = src_q.size();
    while (src_q.size() < n_directed + 75) add_text();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < src_q.size(); i++) begin
      if (i % 20 == 0) gap_pct = pick_odds();
      calm_tail = (src_q.size() - i <= 15);
      send_byte(src_q[i]);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.faults == 0) begin
      $display("tb_script_lexer_byte_stream: clean");
    end else begin
      $display("tb_script_lexer_byte_stream: errors");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb_script_lexer_byte_stream: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
design/slx_pkg.sv
design/slx_core.sv
design/script_lexer_byte_stream.sv
test/tb_script_lexer_byte_stream.sv
